[src/fdc_pkg.sv]
// Shared constants, register indexes and the soft-clip table for the delay/chorus block.
package fdc_pkg;

	localparam int BUFFER_DEPTH_DEF = 65536;
	localparam int SAMPLE_WIDTH_DEF = 16;

	localparam int CFG_AW = 3;
	localparam int CFG_DW = 18;

	typedef enum logic [CFG_AW-1:0] {
		CFG_MODE       = 3'd0,
		CFG_DELAY_TIME = 3'd1,
		CFG_FB_GAIN    = 3'd2,
		CFG_WET_MIX    = 3'd3,
		CFG_SRATE      = 3'd4,
		CFG_SMOOTH     = 3'd5
	} cfg_idx_t;

	localparam logic [16:0] WET_RESET    = 17'd32768;
	localparam logic [17:0] SRATE_RESET  = 18'd48000;
	localparam logic [15:0] SMOOTH_RESET = 16'd66;
	localparam logic [16:0] WET_FULL     = 17'd65536;

	// 3 ms in units of 2^-31 s and 2 ms in units of 2^-31 s at full-scale Q1.15 modulation
	localparam int CHORUS_BASE  = 6442451;
	localparam int CHORUS_DEPTH = 4294967;
	// floor(x / 5) = (x * FIVE_RECIP) >> 18 for x < 2^18
	localparam int FIVE_RECIP   = 52429;
	localparam logic [15:0] CLIP_MAX = 16'd32606;
	localparam logic [5:0]  CLIP_IDX_SAT = 6'd24;

	// tanh(k/8) in Q1.15; anything past the last entry is the last entry
	function automatic logic [15:0] tanh_lut(input logic [4:0] k);
		logic [15:0] v;
		unique case (k)
			5'd0:  v = 16'd0;
			5'd1:  v = 16'd4075;
			5'd2:  v = 16'd8025;
			5'd3:  v = 16'd11743;
			5'd4:  v = 16'd15143;
			5'd5:  v = 16'd18173;
			5'd6:  v = 16'd20813;
			5'd7:  v = 16'd23066;
			5'd8:  v = 16'd24956;
			5'd9:  v = 16'd26519;
			5'd10: v = 16'd27796;
			5'd11: v = 16'd28831;
			5'd12: v = 16'd29660;
			5'd13: v = 16'd30322;
			5'd14: v = 16'd30847;
			5'd15: v = 16'd31262;
			5'd16: v = 16'd31589;
			5'd17: v = 16'd31846;
			5'd18: v = 16'd32048;
			5'd19: v = 16'd32206;
			5'd20: v = 16'd32329;
			5'd21: v = 16'd32426;
			5'd22: v = 16'd32501;
			5'd23: v = 16'd32560;
			default: v = CLIP_MAX;
		endcase
		return v;
	endfunction

endpackage

[src/fdc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fdc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[src/fractional_delay_chorus.sv]
// Feedback delay / chorus with linear-interpolated fractional tap, top level.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one Q1.15 audio sample and one
//   Q1.15 modulation sample per item. Output channel (out_valid/out_ready)
//   returns one Q1.15 mixed sample per item, in order.
//   Configuration is a plain write port (cfg_wr_en, cfg_addr, cfg_wdata);
//   write only while no item is in flight.
//   Each item steps from ST_IDLE through ST_TGT to ST_MIX2, and a new item is
//   accepted only in ST_IDLE; all products run through one shared
//   19x34 signed multiplier with a registered product, stepped by the
//   sequencer, and the two interpolation taps come from the single read port
//   of the delay RAM on consecutive cycles.
//   Reset: configuration registers return to their defaults, write pointer and smoother
//   to zero. The delay RAM is not swept: a wrap flag plus the write pointer
//   tell which entries have been written, and unwritten entries read as zero.
//   Stall: a finished item sits in the output register; the next item is
//   accepted meanwhile and the block holds in its last step until the output
//   register frees.
module fractional_delay_chorus
	import fdc_pkg::*;
#(
	parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] audio_in,
	input  logic signed [15:0] mod_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] audio_out,
	input  logic               cfg_wr_en,
	input  logic [CFG_AW-1:0]  cfg_addr,
	input  logic [CFG_DW-1:0]  cfg_wdata
);

	localparam int AW   = $clog2(BUFFER_DEPTH);
	localparam int SW   = SAMPLE_WIDTH;
	localparam int UP   = (SW > 16) ? SW - 16 : 0;
	localparam int DOWN = (SW < 16) ? 16 - SW : 0;
	localparam int RPW  = AW + 16;
	localparam logic [AW-1:0]  LAST_IDX = AW'(BUFFER_DEPTH - 1);
	localparam logic [RPW-1:0] D_MAX    = {LAST_IDX, 16'd0};
	localparam logic [RPW:0]   TOTAL    = {1'b0, AW'(BUFFER_DEPTH % (1 << AW)), 16'd0}
		| ((BUFFER_DEPTH == (1 << AW)) ? {1'b1, {RPW{1'b0}}} : {(RPW+1){1'b0}});

	typedef enum logic [13:0] {
		ST_IDLE = 14'b00000000000001,
		ST_TGT  = 14'b00000000000010,
		ST_DIFF = 14'b00000000000100,
		ST_SMUL = 14'b00000000001000,
		ST_SUPD = 14'b00000000010000,
		ST_DMUL = 14'b00000000100000,
		ST_RP   = 14'b00000001000000,
		ST_RD0  = 14'b00000010000000,
		ST_RD1  = 14'b00000100000000,
		ST_FBX  = 14'b00001000000000,
		ST_TAP  = 14'b00010000000000,
		ST_CLIP = 14'b00100000000000,
		ST_MIX1 = 14'b01000000000000,
		ST_MIX2 = 14'b10000000000000
	} state_t;

	state_t state_q;

	// configuration
	logic        mode_q;
	logic [16:0] delay_time_q;
	logic [15:0] fb_gain_q;
	logic [16:0] wet_q;
	logic [17:0] srate_q;
	logic [15:0] smooth_q;

	// per-item and persistent state
	logic signed [15:0]   audio_q, mod_q;
	logic [31:0]          s_q;
	logic signed [33:0]   diff_q;
	logic [AW-1:0]        wp_q;
	logic                 wrapped_q;
	logic [AW-1:0]        i0_q, i1_q;
	logic [15:0]          frac_q;
	logic                 v0_q, v1_q;
	logic signed [SW-1:0] y0_q;
	logic                 fbneg_q;
	logic signed [17:0]   fb_q;
	logic signed [15:0]   tap_q, last_tap_q;
	logic                 neg_q, sat_q;
	logic [15:0]          lo_q;
	logic signed [52:0]   acc_q;
	logic                 out_valid_q;
	logic signed [15:0]   audio_out_q;

	// shared multiplier
	logic signed [18:0] mul_a;
	logic signed [33:0] mul_b;
	logic signed [52:0] prod_q;

	// RAM
	logic          ram_we;
	logic [AW-1:0] ram_raddr;
	logic [SW-1:0] ram_wdata, ram_rdata;

	logic in_acc, slot_free, load_out;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign load_out  = (state_q == ST_MIX2) && slot_free;

	// combinational datapath pieces
	logic signed [52:0] chorus_off, smooth_step, mix_sum;
	logic signed [33:0] target;
	logic [37:0]        d_full;
	logic [RPW-1:0]     d_sat;
	logic [RPW:0]       rp_raw, rp_fix;
	logic [RPW-1:0]     rp;
	logic [AW-1:0]      rp_i0, rp_i1;
	logic signed [32:0] fb_p;
	logic [32:0]        fb_abs;
	logic [35:0]        fb_x6;
	logic [15:0]        fb_mag;
	logic signed [SW-1:0] y1_v;
	logic signed [SW:0]   y_dif;
	logic signed [SW+1:0] ts_sum;
	logic signed [39:0]   fs_ext, st_ext;
	logic signed [18:0]   x_sum;
	logic [17:0]          x_abs;
	logic [5:0]           x_idx;
	logic [15:0]          t_lo, t_hi;
	logic signed [52:0]   clip_add;
	logic [15:0]          clip_y;
	logic signed [16:0]   clip_v;
	logic [16:0]          wet_eff;
	logic signed [52:0]   mix_ext;

	always_comb begin
		chorus_off  = (prod_q + 53'sd16384) >>> 15;
		target      = mode_q ? (34'(CHORUS_BASE) + 34'(chorus_off))
		                     : $signed({2'b00, delay_time_q, 15'd0});
		smooth_step = (prod_q + 53'sd32768) >>> 16;

		d_full = prod_q[52:15];
		d_sat  = (d_full > 38'(D_MAX)) ? D_MAX : d_full[RPW-1:0];
		rp_raw = {1'b0, wp_q, 16'd0} - {1'b0, d_sat};
		rp_fix = rp_raw[RPW] ? (rp_raw + TOTAL) : rp_raw;
		rp     = rp_fix[RPW-1:0];
		rp_i0  = rp[RPW-1:16];
		rp_i1  = (rp_i0 == LAST_IDX) ? '0 : rp_i0 + AW'(1);

		fb_p   = prod_q[32:0];
		fb_abs = fb_p[32] ? 33'(-fb_p) : fb_p;
		fb_x6  = {1'b0, fb_abs, 2'b00} + {2'b00, fb_abs, 1'b0};
		fb_mag = prod_q[33:18];

		y1_v   = v1_q ? $signed(ram_rdata) : '0;
		y_dif  = (SW+1)'(y1_v) - (SW+1)'(y0_q);

		ts_sum = (SW+2)'(y0_q) + (SW+2)'(prod_q >>> 16);
		fs_ext = (40'(ts_sum[SW-1:0]) >>> UP) <<< DOWN;

		x_sum  = 19'(audio_q) + 19'(fb_q);
		x_abs  = x_sum[18] ? 18'(-x_sum) : x_sum[17:0];
		x_idx  = x_abs[17:12];
		t_lo   = tanh_lut(x_idx[4:0]);
		t_hi   = tanh_lut(x_idx[4:0] + 5'd1);

		clip_add = (prod_q + 53'sd2048) >>> 12;
		clip_y   = sat_q ? CLIP_MAX : lo_q + clip_add[15:0];
		clip_v   = neg_q ? -$signed({1'b0, clip_y}) : $signed({1'b0, clip_y});
		st_ext   = (40'(clip_v) <<< UP) >>> DOWN;

		wet_eff  = (wet_q > WET_FULL) ? WET_FULL : wet_q;
		mix_ext  = acc_q + prod_q + 53'sd32768;
		mix_sum  = mix_ext >>> 16;
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_TGT: begin
				mul_a = 19'(mod_q);
				mul_b = 34'(CHORUS_DEPTH);
			end
			ST_SMUL: begin
				mul_a = $signed({3'b000, smooth_q});
				mul_b = diff_q;
			end
			ST_DMUL: begin
				mul_a = $signed({1'b0, srate_q});
				mul_b = $signed({2'b00, s_q});
			end
			ST_RD0: begin
				mul_a = 19'(last_tap_q);
				mul_b = $signed({18'd0, fb_gain_q});
			end
			ST_RD1: begin
				mul_a = 19'(FIVE_RECIP);
				mul_b = $signed({14'd0, fb_x6[35:16]});
			end
			ST_FBX: begin
				mul_a = $signed({3'b000, frac_q});
				mul_b = 34'(y_dif);
			end
			ST_TAP: begin
				mul_a = $signed({3'b000, t_hi - t_lo});
				mul_b = $signed({22'd0, x_abs[11:0]});
			end
			ST_CLIP: begin
				mul_a = 19'(audio_q);
				mul_b = $signed({17'd0, WET_FULL - wet_eff});
			end
			ST_MIX1, ST_MIX2: begin
				mul_a = 19'(tap_q);
				mul_b = $signed({17'd0, wet_eff});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	assign ram_raddr = (state_q == ST_RD1) ? i1_q : i0_q;
	assign ram_we    = (state_q == ST_CLIP);
	assign ram_wdata = st_ext[SW-1:0];

	fdc_ram #(
		.WIDTH(SW),
		.DEPTH(BUFFER_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wp_q),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// configuration writes; mask each value to its register width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= 1'b0;
			delay_time_q <= '0;
			fb_gain_q    <= '0;
			wet_q        <= WET_RESET;
			srate_q      <= SRATE_RESET;
			smooth_q     <= SMOOTH_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				CFG_MODE:       mode_q       <= cfg_wdata[0];
				CFG_DELAY_TIME: delay_time_q <= cfg_wdata[16:0];
				CFG_FB_GAIN:    fb_gain_q    <= cfg_wdata[15:0];
				CFG_WET_MIX:    wet_q        <= cfg_wdata[16:0];
				CFG_SRATE:      srate_q      <= cfg_wdata[17:0];
				CFG_SMOOTH:     smooth_q     <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// sequencer and persistent state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			s_q         <= '0;
			wp_q        <= '0;
			wrapped_q   <= 1'b0;
			last_tap_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// present a finished item, or drop the one the receiver took
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: if (in_acc) begin
					state_q <= ST_TGT;
				end
				ST_TGT:  state_q <= ST_DIFF;
				ST_DIFF: state_q <= ST_SMUL;
				ST_SMUL: state_q <= ST_SUPD;
				ST_SUPD: begin
					s_q     <= s_q + smooth_step[31:0];
					state_q <= ST_DMUL;
				end
				ST_DMUL: state_q <= ST_RP;
				ST_RP:   state_q <= ST_RD0;
				ST_RD0:  state_q <= ST_RD1;
				ST_RD1:  state_q <= ST_FBX;
				ST_FBX:  state_q <= ST_TAP;
				ST_TAP:  state_q <= ST_CLIP;
				ST_CLIP: begin
					last_tap_q <= tap_q;
					state_q    <= ST_MIX1;
				end
				ST_MIX1: state_q <= ST_MIX2;
				ST_MIX2: if (slot_free) begin
					if (wp_q == LAST_IDX) begin
						wp_q      <= '0;
						wrapped_q <= 1'b1;
					end else begin
						wp_q <= wp_q + AW'(1);
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			audio_q <= audio_in;
			mod_q   <= mod_in;
		end
		if (state_q == ST_DIFF) begin
			diff_q <= target - $signed({2'b00, s_q});
		end
		if (state_q == ST_RP) begin
			i0_q   <= rp_i0;
			i1_q   <= rp_i1;
			frac_q <= rp[15:0];
			// unwritten slots read as zero
			v0_q   <= wrapped_q || (rp_i0 < wp_q);
			v1_q   <= wrapped_q || (rp_i1 < wp_q);
		end
		if (state_q == ST_RD1) begin
			y0_q    <= v0_q ? $signed(ram_rdata) : '0;
			fbneg_q <= fb_p[32];
		end
		if (state_q == ST_FBX) begin
			fb_q <= mode_q ? 18'sd0
			               : (fbneg_q ? -$signed({2'b00, fb_mag}) : $signed({2'b00, fb_mag}));
		end
		if (state_q == ST_TAP) begin
			tap_q <= fs_ext[15:0];
			neg_q <= x_sum[18];
			sat_q <= (x_idx >= CLIP_IDX_SAT);
			lo_q  <= t_lo;
		end
		if (state_q == ST_MIX1) begin
			acc_q <= prod_q;
		end
		if (load_out) begin
			if (mix_sum > 53'sd32767) begin
				audio_out_q <= 16'sh7FFF;
			end else if (mix_sum < -53'sd32768) begin
				audio_out_q <= -16'sh8000;
			end else begin
				audio_out_q <= mix_sum[15:0];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign audio_out = audio_out_q;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("accepted a second item while busy");

	a_out_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q)
		else $error("finished item not presented");

	a_wp_moves_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(wp_q) |-> $past(load_out))
		else $error("write pointer moved without a finished item");

	a_tap_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD0) |-> (i0_q <= LAST_IDX && i1_q <= LAST_IDX))
		else $error("read index outside the delay store");
`endif

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the fractional delay / chorus block.
module tb_top
	import fdc_pkg::*;
();

	localparam int DEPTH = 65536;
	localparam int CYCLE_LIMIT = 600000;
	localparam int N_PHASES = 9;
	localparam int ITEMS_PER_PHASE = 104;
	localparam int LONG_STALL = 400;

	// Behavioral echo of the delay line: tracks its own buffer, pointer, smoother
	// and registers, and keeps the expected output samples in arrival order.
	class echo_scoreboard;
		logic signed [15:0] line_mem [DEPTH];
		int unsigned wr_ptr;
		longint unsigned smooth_s;
		longint prev_tap;
		logic mode_r;
		longint unsigned dtime_r, fbg_r, wet_r, srate_r, coef_r;
		logic signed [15:0] expected_out [$];
		int mismatches;
		int clip_tab [25] = '{0, 4075, 8025, 11743, 15143, 18173, 20813, 23066, 24956,
			26519, 27796, 28831, 29660, 30322, 30847, 31262, 31589,
			31846, 32048, 32206, 32329, 32426, 32501, 32560, 32606};

		function new();
			foreach (line_mem[k]) line_mem[k] = '0;
			wr_ptr = 0; smooth_s = 0; prev_tap = 0;
			mode_r = 0; dtime_r = 0; fbg_r = 0; wet_r = 32768; srate_r = 48000; coef_r = 66;
			mismatches = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, longint unsigned v);
			case (idx)
				CFG_MODE:       mode_r = v[0];
				CFG_DELAY_TIME: dtime_r = v & 64'h1FFFF;
				CFG_FB_GAIN:    fbg_r = v & 64'hFFFF;
				CFG_WET_MIX:    wet_r = v & 64'h1FFFF;
				CFG_SRATE:      srate_r = v & 64'h3FFFF;
				CFG_SMOOTH:     coef_r = v & 64'hFFFF;
				default: ;
			endcase
		endfunction

		function longint clip_ref(longint x);
			longint a, y, lo, hi;
			int unsigned idx;
			a = (x < 0) ? -x : x;
			idx = 32'(a >> 12);
			if (idx >= 24) begin
				y = longint'(clip_tab[24]);
			end else begin
				lo = longint'(clip_tab[idx]);
				hi = longint'(clip_tab[idx + 1]);
				y = lo + (((hi - lo) * (a & 4095) + 2048) >>> 12);
			end
			return (x < 0) ? -y : y;
		endfunction

		// Advance the echo by one accepted item and queue its output sample.
		function void note_input(logic signed [15:0] audio, logic signed [15:0] modv);
			longint aud, md, target, diff, step, y0, y1, tap, fb, mix;
			longint unsigned d, total, rp, wet;
			int unsigned i0, i1, frac;
			aud = audio;
			md = modv;
			if (!mode_r)
				target = longint'(dtime_r) << 15;
			else
				target = CHORUS_BASE + ((longint'(CHORUS_DEPTH) * md + 16384) >>> 15);
			diff = target - longint'(smooth_s);
			step = (longint'(coef_r) * diff + 32768) >>> 16;
			smooth_s = (smooth_s + 64'(step)) & 64'hFFFF_FFFF;

			d = (smooth_s * srate_r) >> 15;
			if (d > (longint'(DEPTH - 1) << 16)) d = longint'(DEPTH - 1) << 16;
			total = longint'(DEPTH) << 16;
			rp = ((longint'(wr_ptr) << 16) + total - d) % total;
			i0 = 32'(rp >> 16);
			frac = 32'(rp & 64'hFFFF);
			i1 = (i0 + 1 >= DEPTH) ? 0 : i0 + 1;
			y0 = line_mem[i0];
			y1 = line_mem[i1];
			tap = y0 + (((y1 - y0) * longint'(frac)) >>> 16);

			// feedback from the previous tap, truncated toward zero; none in chorus
			fb = mode_r ? 0 : (prev_tap * longint'(fbg_r) * 6) / 327680;
			line_mem[wr_ptr] = 16'(clip_ref(aud + fb));
			prev_tap = tap;

			wet = (wet_r > 65536) ? 65536 : wet_r;
			mix = (aud * longint'(65536 - wet) + tap * longint'(wet) + 32768) >>> 16;
			if (mix > 32767) mix = 32767;
			if (mix < -32768) mix = -32768;
			expected_out.push_back(16'(mix));
			wr_ptr = (wr_ptr + 1 >= DEPTH) ? 0 : wr_ptr + 1;
		endfunction

		function void check_result(logic signed [15:0] got);
			logic signed [15:0] want;
			if (expected_out.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output item: audio_out=%0d", got);
				return;
			end
			want = expected_out.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("audio_out mismatch: expected %0d, got %0d", want, got);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] audio_in = '0;
	logic signed [15:0] mod_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] audio_out;
	logic cfg_wr_en = 1'b0;
	logic [CFG_AW-1:0] cfg_addr = '0;
	logic [CFG_DW-1:0] cfg_wdata = '0;

	echo_scoreboard sb = new();
	int unsigned cyc = 0;
	int burst_left = 0;
	bit long_stall_req = 0;
	int stall_cnt = 0;

	fractional_delay_chorus u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.audio_in(audio_in), .mod_in(mod_in),
		.out_valid(out_valid), .out_ready(out_ready), .audio_out(audio_out),
		.cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	// Watchdog: a correct run finishes far below this.
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Receiver: check each accepted item, then pick the next ready value.
	// Stall patterns change with the cycle count; once requested, a long hold-off
	// counted here lets the block fill up so that it has to drop in_ready while
	// the sender keeps offering.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(audio_out);
		if (!arst_n)
			out_ready <= 1'b0;
		else if (long_stall_req && stall_cnt < LONG_STALL) begin
			out_ready <= 1'b0;
			stall_cnt <= stall_cnt + 1;
		end else case (cyc[12:11])
			2'd0: out_ready <= 1'b1;
			2'd1: out_ready <= ($urandom_range(0, 3) != 0);
			2'd2: out_ready <= ($urandom_range(0, 1) != 0);
			default: out_ready <= (cyc[4:2] != 3'd0);
		endcase
	end

	// Offer one item; called right after a rising edge, returns after acceptance.
	task automatic send_sample(logic signed [15:0] a, logic signed [15:0] m);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 1) ? $urandom_range(1, 40) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		in_valid <= 1'b1;
		audio_in <= a;
		mod_in <= m;
		do @(posedge clk); while (!in_ready);
		sb.note_input(a, m);
		burst_left--;
	endtask

	// Drop valid and wait until every queued result is back.
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.expected_out.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Leaves the write enable high; write_all drops it after the last register.
	task automatic write_reg(cfg_idx_t idx, logic [CFG_DW-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		sb.set_reg(idx, 64'(v));
	endtask

	task automatic write_all(logic m, int dt, int fbg, int wet, int sr, int sm);
		write_reg(CFG_MODE, CFG_DW'(m));
		write_reg(CFG_DELAY_TIME, CFG_DW'(dt));
		write_reg(CFG_FB_GAIN, CFG_DW'(fbg));
		write_reg(CFG_WET_MIX, CFG_DW'(wet));
		write_reg(CFG_SRATE, CFG_DW'(sr));
		write_reg(CFG_SMOOTH, CFG_DW'(sm));
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic signed [15:0] edgy();
		case ($urandom_range(0, 7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sd0;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic signed [15:0] corner [6];
		int hold;
		corner = '{16'sh7FFF, 16'sh8000, 16'sd0, -16'sd1, 16'sd1, 16'sh4000};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: zero delay reads the oldest slot; extremes of both fields.
		foreach (corner[a])
			send_sample(corner[a], corner[5 - a]);
		send_sample(16'sh7FFF, 16'sh7FFF);
		send_sample(16'sh8000, 16'sh8000);
		drain();

		// Chorus, wet above one, fast smoother: modulation extremes.
		write_all(1'b1, 0, 65535, 131071, 48000, 65535);
		foreach (corner[a])
			send_sample(corner[a], corner[a]);
		drain();

		// Full feedback, very short delay, loud input: soft clip and feedback.
		write_all(1'b0, 1, 65535, 65536, 192000, 65535);
		for (int k = 0; k < 8; k++)
			send_sample(k[0] ? 16'sh7FFF : 16'sh8000, 16'sd0);
		drain();

		// Random phases; the first few pin extremes of the registers.
		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				0: write_all(1'b0, 65536, 65535, 65536, 192000, 65535);
				1: write_all(1'b0, 20, 40000, 0, 8000, 0);
				2: write_all(1'b0, 3, 65535, 40000, 0, 30000);
				3: write_all(1'b0, 65536, 20000, 50000, 262143, 65535);
				4: write_all(1'b1, 100, 0, 65536, 8000, 65535);
				default: write_all(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0 ?
					$urandom_range(0, 131071) : $urandom_range(0, 700),
					$urandom_range(0, 65535), $urandom_range(0, 70000),
					$urandom_range(8000, 192000), $urandom_range(1000, 65535));
			endcase
			// hold off the receiver for a long stretch while this phase streams
			if (p == 3)
				long_stall_req = 1;
			for (int k = 0; k < ITEMS_PER_PHASE; k++)
				send_sample(edgy(), edgy());
			drain();
		end

		hold = 0;
		while (sb.expected_out.size() != 0 && hold < 5000) begin
			@(posedge clk);
			hold++;
		end
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_out.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
